/* rtl/core/gaps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid path search package
// Word types, command and status codes and a control bundle shared by the
// grid path search modules.
// ----------------------------------------------------------------------------
package gaps_pkg;

    localparam int FIELD_W = 3;
    localparam int DIM_W   = 4;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;

    localparam logic [1:0] ST_PATH    = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [1:0] DIR_POS_X = 2'd0;
    localparam logic [1:0] DIR_POS_Y = 2'd1;
    localparam logic [1:0] DIR_NEG_X = 2'd2;
    localparam logic [1:0] DIR_NEG_Y = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [FIELD_W-1:0] cell_x;
        logic [FIELD_W-1:0] cell_y;
        logic [FIELD_W-1:0] goal_x;
        logic [FIELD_W-1:0] goal_y;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] step_x;
        logic [FIELD_W-1:0] step_y;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic eval;
    } t_min_ctl;

endpackage

/* rtl/core/gaps_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/gaps_min_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum f unit
// Forms f = g + Manhattan distance to the goal for one open cell per cycle
// and keeps the first cell with the smallest f seen since the last clear.
// ----------------------------------------------------------------------------
module gaps_min_unit #(
    parameter int XW = 3,
    parameter int YW = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gaps_pkg::t_min_ctl   i_ctl,
    input  logic [XW+YW-1:0]     i_cell,
    input  logic [XW+YW:0]       i_cost,
    input  logic [XW+YW-1:0]     i_goal,
    output logic                 o_found,
    output logic [XW+YW-1:0]     o_best,
    output logic [XW+YW:0]       o_best_cost
);

    localparam int CW = XW + YW;
    localparam int FW = CW + 2;

    logic [XW-1:0] w_cx;
    logic [XW-1:0] w_gx;
    logic [YW-1:0] w_cy;
    logic [YW-1:0] w_gy;
    logic [XW-1:0] w_dx;
    logic [YW-1:0] w_dy;
    logic [FW-1:0] w_f;
    logic          r_found;
    logic [CW-1:0] r_best;
    logic [CW:0]   r_best_cost;
    logic [FW-1:0] r_best_f;

    assign w_cx = i_cell[XW-1:0];
    assign w_cy = i_cell[CW-1:XW];
    assign w_gx = i_goal[XW-1:0];
    assign w_gy = i_goal[CW-1:XW];
    assign w_dx = (w_cx >= w_gx) ? (w_cx - w_gx) : (w_gx - w_cx);
    assign w_dy = (w_cy >= w_gy) ? (w_cy - w_gy) : (w_gy - w_cy);
    assign w_f  = FW'(i_cost) + FW'(w_dx) + FW'(w_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.eval && (!r_found || w_f < r_best_f)) begin
            r_found     <= 1'b1;
            r_best      <= i_cell;
            r_best_cost <= i_cost;
            r_best_f    <= w_f;
        end
    end

    assign o_found     = r_found;
    assign o_best      = r_best;
    assign o_best_cost = r_best_cost;

endmodule

/* rtl/core/grid_astar_path_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* path search
// Obstacle map with a 4-neighbour A* search over a small grid.
// ----------------------------------------------------------------------------
// A find path word holds the block busy for the whole search: every expansion
// scans all MAX_COLUMNS*MAX_ROWS cells through one cost memory read port and
// one shared f compare unit, then tries the four neighbours in turn. The path
// is traced back at one cell per cycle and then sent out one cell at a time,
// each cell read from the stack memory before it waits for the receiver.
// ----------------------------------------------------------------------------
module grid_astar_path_search #(
    parameter int MAX_COLUMNS = 8,
    parameter int MAX_ROWS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  gaps_pkg::t_in_word            i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output gaps_pkg::t_out_word           o_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [gaps_pkg::DIM_W-1:0]    i_cfg_data
);

    localparam int XW     = $clog2(MAX_COLUMNS);
    localparam int YW     = $clog2(MAX_ROWS);
    localparam int CW     = XW + YW;
    localparam int NMEM   = 1 << CW;
    localparam int NCELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int DW     = gaps_pkg::DIM_W;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_SCAN      = 10'b0000000010,
        S_SCAN_TAIL = 10'b0000000100,
        S_DECIDE    = 10'b0000001000,
        S_EXP_RD    = 10'b0000010000,
        S_EXP_WR    = 10'b0000100000,
        S_TRACE     = 10'b0001000000,
        S_EMIT_RD   = 10'b0010000000,
        S_EMIT_OUT  = 10'b0100000000,
        S_STATUS    = 10'b1000000000
    } t_state;

    t_state                r_state;
    logic [DW-1:0]         r_cfg_w;
    logic [DW-1:0]         r_cfg_h;
    logic [NMEM-1:0]       r_obst;
    logic [NMEM-1:0]       r_disc;
    logic [NMEM-1:0]       r_open;
    logic [CW-1:0]         r_start;
    logic [CW-1:0]         r_goal;
    logic [XW-1:0]         r_sx;
    logic [YW-1:0]         r_sy;
    logic                  r_ev_valid;
    logic [CW-1:0]         r_ev_cell;
    logic [1:0]            r_dir;
    logic [CW-1:0]         r_nb;
    logic [CW:0]           r_n;
    logic [CW-1:0]         r_pos;
    logic [1:0]            r_status;
    logic                  r_out_valid;
    gaps_pkg::t_out_word   r_out;

    logic [DW-1:0]         w_w;
    logic [DW-1:0]         w_h;
    logic                  w_accept;
    logic [DW-1:0]         w_sx4;
    logic [DW-1:0]         w_sy4;
    logic [DW-1:0]         w_gx4;
    logic [DW-1:0]         w_gy4;
    logic                  w_in_store;
    logic                  w_outside;
    logic [CW-1:0]         w_in_cell;
    logic [CW-1:0]         w_in_goal;
    logic                  w_find_go;
    logic                  w_scan_last;
    logic [DW-1:0]         w_bx;
    logic [DW-1:0]         w_by;
    logic [DW-1:0]         w_nx;
    logic [DW-1:0]         w_ny;
    logic                  w_nb_ok;
    logic [CW-1:0]         w_nb;
    logic                  w_nb_valid;
    logic [CW:0]           w_g;
    logic                  w_upd;
    logic                  w_out_free;
    logic                  w_out_load;
    gaps_pkg::t_min_ctl    w_min_ctl;
    logic                  w_found;
    logic [CW-1:0]         w_best;
    logic [CW:0]           w_best_cost;

    logic                  w_cost_we;
    logic [CW-1:0]         w_cost_waddr;
    logic [CW:0]           w_cost_wdata;
    logic [CW-1:0]         w_cost_raddr;
    logic [CW:0]           w_cost_rdata;
    logic                  w_par_we;
    logic [CW-1:0]         w_par_raddr;
    logic [CW-1:0]         w_par_rdata;
    logic                  w_stk_we;
    logic [CW-1:0]         w_stk_rdata;

    assign w_w = (r_cfg_w > DW'(MAX_COLUMNS)) ? DW'(MAX_COLUMNS) : r_cfg_w;
    assign w_h = (r_cfg_h > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : r_cfg_h;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;

    assign w_sx4      = DW'(i_data.cell_x);
    assign w_sy4      = DW'(i_data.cell_y);
    assign w_gx4      = DW'(i_data.goal_x);
    assign w_gy4      = DW'(i_data.goal_y);
    assign w_in_store = (w_sx4 < DW'(MAX_COLUMNS)) && (w_sy4 < DW'(MAX_ROWS));
    assign w_outside  = (w_sx4 >= w_w) || (w_sy4 >= w_h) || (w_gx4 >= w_w) || (w_gy4 >= w_h);
    assign w_in_cell  = {i_data.cell_y[YW-1:0], i_data.cell_x[XW-1:0]};
    assign w_in_goal  = {i_data.goal_y[YW-1:0], i_data.goal_x[XW-1:0]};
    assign w_find_go  = w_accept && (i_data.command == gaps_pkg::CMD_FIND) && !w_outside
                        && (w_in_cell != w_in_goal);

    assign w_scan_last = (r_sx == XW'(MAX_COLUMNS - 1)) && (r_sy == YW'(MAX_ROWS - 1));

    assign w_bx = DW'(w_best[XW-1:0]);
    assign w_by = DW'(w_best[CW-1:XW]);

    always_comb begin
        w_nx    = w_bx;
        w_ny    = w_by;
        w_nb_ok = 1'b0;
        unique case (r_dir)
            gaps_pkg::DIR_POS_X: begin
                w_nx    = w_bx + DW'(1);
                w_nb_ok = (w_bx + DW'(1)) < w_w;
            end
            gaps_pkg::DIR_POS_Y: begin
                w_ny    = w_by + DW'(1);
                w_nb_ok = (w_by + DW'(1)) < w_h;
            end
            gaps_pkg::DIR_NEG_X: begin
                w_nx    = w_bx - DW'(1);
                w_nb_ok = (w_bx != '0);
            end
            default: begin
                w_ny    = w_by - DW'(1);
                w_nb_ok = (w_by != '0);
            end
        endcase
    end

    assign w_nb       = {w_ny[YW-1:0], w_nx[XW-1:0]};
    assign w_nb_valid = w_nb_ok && !(r_obst[w_nb] && (w_nb != r_goal));
    assign w_g        = w_best_cost + (CW+1)'(1);
    assign w_upd      = !r_disc[r_nb] || (w_g < w_cost_rdata);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_out_load = ((r_state == S_EMIT_OUT) || (r_state == S_STATUS)) && w_out_free;

    assign w_min_ctl.clear = (r_state == S_SCAN) && (r_sx == '0) && (r_sy == '0);
    assign w_min_ctl.eval  = r_ev_valid && r_open[r_ev_cell];

    assign w_cost_we    = w_find_go || ((r_state == S_EXP_WR) && w_upd);
    assign w_cost_waddr = (r_state == S_EXP_WR) ? r_nb : w_in_cell;
    assign w_cost_wdata = (r_state == S_EXP_WR) ? w_g : '0;
    assign w_cost_raddr = (r_state == S_EXP_RD) ? w_nb : {r_sy, r_sx};
    assign w_par_we     = (r_state == S_EXP_WR) && w_upd;
    assign w_par_raddr  = (r_state == S_TRACE) ? w_par_rdata : r_goal;
    assign w_stk_we     = (r_state == S_TRACE) && (w_par_rdata != r_start)
                          && (r_n != (CW+1)'(NCELLS));

    gaps_min_unit #(
        .XW (XW),
        .YW (YW)
    ) u_min (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_min_ctl),
        .i_cell      (r_ev_cell),
        .i_cost      (w_cost_rdata),
        .i_goal      (r_goal),
        .o_found     (w_found),
        .o_best      (w_best),
        .o_best_cost (w_best_cost)
    );

    gaps_ram #(
        .WIDTH (CW + 1),
        .DEPTH (NMEM)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_cost_we),
        .i_waddr (w_cost_waddr),
        .i_wdata (w_cost_wdata),
        .i_raddr (w_cost_raddr),
        .o_rdata (w_cost_rdata)
    );

    gaps_ram #(
        .WIDTH (CW),
        .DEPTH (NMEM)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_we),
        .i_waddr (r_nb),
        .i_wdata (w_best),
        .i_raddr (w_par_raddr),
        .o_rdata (w_par_rdata)
    );

    gaps_ram #(
        .WIDTH (CW),
        .DEPTH (NMEM)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_n[CW-1:0]),
        .i_wdata (w_par_rdata),
        .i_raddr (r_pos),
        .o_rdata (w_stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= DW'(8);
            r_cfg_h     <= DW'(8);
            r_obst      <= '0;
            r_disc      <= '0;
            r_open      <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == gaps_pkg::CFG_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                end else begin
                    r_cfg_h <= i_cfg_data;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_ev_valid <= (r_state == S_SCAN);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_data.command)
                            gaps_pkg::CMD_SET, gaps_pkg::CMD_CLEAR: begin
                                if (w_in_store) begin
                                    r_obst[w_in_cell] <= (i_data.command == gaps_pkg::CMD_SET);
                                end
                            end
                            gaps_pkg::CMD_FIND: begin
                                r_start <= w_in_cell;
                                r_goal  <= w_in_goal;
                                if (w_outside) begin
                                    r_status <= gaps_pkg::ST_OUTSIDE;
                                    r_state  <= S_STATUS;
                                end else if (w_in_cell == w_in_goal) begin
                                    r_status <= gaps_pkg::ST_EMPTY;
                                    r_state  <= S_STATUS;
                                end else begin
                                    r_disc  <= NMEM'(1) << w_in_cell;
                                    r_open  <= NMEM'(1) << w_in_cell;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_ev_cell <= {r_sy, r_sx};
                    if (r_sx == XW'(MAX_COLUMNS - 1)) begin
                        r_sx <= '0;
                        r_sy <= w_scan_last ? '0 : r_sy + YW'(1);
                    end else begin
                        r_sx <= r_sx + XW'(1);
                    end
                    if (w_scan_last) begin
                        r_state <= S_SCAN_TAIL;
                    end
                end
                S_SCAN_TAIL: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!w_found) begin
                        r_status <= gaps_pkg::ST_NONE;
                        r_state  <= S_STATUS;
                    end else if (w_best == r_goal) begin
                        r_n     <= '0;
                        r_state <= S_TRACE;
                    end else begin
                        r_open[w_best] <= 1'b0;
                        r_dir          <= gaps_pkg::DIR_POS_X;
                        r_state        <= S_EXP_RD;
                    end
                end
                S_EXP_RD: begin
                    if (w_nb_valid) begin
                        r_nb    <= w_nb;
                        r_state <= S_EXP_WR;
                    end else if (r_dir == gaps_pkg::DIR_NEG_Y) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_dir <= r_dir + 2'd1;
                    end
                end
                S_EXP_WR: begin
                    if (w_upd) begin
                        r_disc[r_nb] <= 1'b1;
                        r_open[r_nb] <= 1'b1;
                    end
                    if (r_dir == gaps_pkg::DIR_NEG_Y) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_dir   <= r_dir + 2'd1;
                        r_state <= S_EXP_RD;
                    end
                end
                S_TRACE: begin
                    if (w_stk_we) begin
                        r_n <= r_n + (CW+1)'(1);
                    end else if (r_n == '0) begin
                        r_status <= gaps_pkg::ST_EMPTY;
                        r_state  <= S_STATUS;
                    end else begin
                        r_pos   <= CW'(r_n - (CW+1)'(1));
                        r_state <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_OUT;
                end
                S_EMIT_OUT: begin
                    if (w_out_free) begin
                        r_out.status  <= gaps_pkg::ST_PATH;
                        r_out.step_x  <= gaps_pkg::FIELD_W'(w_stk_rdata[XW-1:0]);
                        r_out.step_y  <= gaps_pkg::FIELD_W'(w_stk_rdata[CW-1:XW]);
                        r_out.last    <= (r_pos == '0);
                        if (r_pos == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos - CW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_STATUS: begin
                    if (w_out_free) begin
                        r_out.status <= r_status;
                        r_out.step_x <= '0;
                        r_out.step_y <= '0;
                        r_out.last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_status_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status != gaps_pkg::ST_PATH)
        |-> o_data.last && (o_data.step_x == '0) && (o_data.step_y == '0))
        else $error("status word with coordinates or without last");

    a_no_obstacle_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP_WR) |-> (!r_obst[r_nb] || (r_nb == r_goal)))
        else $error("expansion entered an obstacle cell");

    a_path_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == gaps_pkg::ST_PATH)
        |-> (DW'(o_data.step_x) < w_w) && (DW'(o_data.step_y) < w_h))
        else $error("path cell outside the grid");

    a_busy_while_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_find_go) |-> (r_state == S_SCAN) && r_open[r_start])
        else $error("search did not start with the start cell open");

endmodule

/* dv/grid_astar_path_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* path search testbench
// Drives obstacle and find path words into the block through several grid
// sizes and idling patterns. A scoreboard models the obstacle map and the A*
// search and checks every output word against the predicted path and status words.
// ----------------------------------------------------------------------------
module grid_astar_path_search_tb;

    localparam int COLS        = 8;
    localparam int ROWS        = 8;
    localparam int NCELL       = COLS * ROWS;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN       = 64;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    class path_scoreboard;
        bit                  blocked [NCELL];
        int                  width_reg;
        int                  height_reg;
        gaps_pkg::t_out_word pending_steps[$];
        int                  mismatches;
        int                  words_checked;
        int                  searches;

        function new();
            width_reg  = COLS;
            height_reg = ROWS;
        endfunction

        function void push_step(logic [1:0] st, int x, int y, bit fin);
            gaps_pkg::t_out_word w;
            w.status = st;
            w.step_x = x[2:0];
            w.step_y = y[2:0];
            w.last   = fin;
            pending_steps = {pending_steps, w};
        endfunction

        function void set_register(logic idx, int value);
            if (idx == gaps_pkg::CFG_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function void plan_route(int sx, int sy, int gx, int gy);
            int  w, h, start, goal, best, bestf, f, nx, ny, nb, g, cur, n;
            int  dx [4];
            int  dy [4];
            bit  seen [NCELL];
            bit  open [NCELL];
            int  cost [NCELL];
            int  parent [NCELL];
            int  trail [NCELL];
            bit  found;
            dx = '{1, 0, -1, 0};
            dy = '{0, 1, 0, -1};
            w = (width_reg > COLS) ? COLS : width_reg;
            h = (height_reg > ROWS) ? ROWS : height_reg;
            searches++;
            if (sx >= w || sy >= h || gx >= w || gy >= h) begin
                push_step(gaps_pkg::ST_OUTSIDE, 0, 0, 1);
                return;
            end
            start = sy * COLS + sx;
            goal  = gy * COLS + gx;
            if (start == goal) begin
                push_step(gaps_pkg::ST_EMPTY, 0, 0, 1);
                return;
            end
            foreach (seen[c]) begin
                seen[c] = 0;
                open[c] = 0;
            end
            seen[start] = 1;
            open[start] = 1;
            cost[start] = 0;
            found = 0;
            forever begin
                best  = NCELL;
                bestf = 0;
                for (int c = 0; c < NCELL; c++) begin
                    if (open[c]) begin
                        f = cost[c] + ((c % COLS > gx) ? c % COLS - gx : gx - c % COLS)
                            + ((c / COLS > gy) ? c / COLS - gy : gy - c / COLS);
                        if (best == NCELL || f < bestf) begin
                            best  = c;
                            bestf = f;
                        end
                    end
                end
                if (best == NCELL) break;
                if (best == goal) begin
                    found = 1;
                    break;
                end
                open[best] = 0;
                for (int d = 0; d < 4; d++) begin
                    nx = best % COLS + dx[d];
                    ny = best / COLS + dy[d];
                    if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                    nb = ny * COLS + nx;
                    if (blocked[nb] && nb != goal) continue;
                    g = cost[best] + 1;
                    if (!seen[nb] || g < cost[nb]) begin
                        seen[nb]   = 1;
                        open[nb]   = 1;
                        cost[nb]   = g;
                        parent[nb] = best;
                    end
                end
            end
            if (!found) begin
                push_step(gaps_pkg::ST_NONE, 0, 0, 1);
                return;
            end
            n   = 0;
            cur = parent[goal];
            while (cur != start && n < NCELL) begin
                trail[n] = cur;
                n++;
                cur = parent[cur];
            end
            if (n == 0) begin
                push_step(gaps_pkg::ST_EMPTY, 0, 0, 1);
                return;
            end
            for (int i = n - 1; i >= 0; i--) begin
                push_step(gaps_pkg::ST_PATH, trail[i] % COLS, trail[i] / COLS, i == 0);
            end
        endfunction

        function void note_command(gaps_pkg::t_in_word cmd);
            if (cmd.command == gaps_pkg::CMD_SET || cmd.command == gaps_pkg::CMD_CLEAR) begin
                blocked[cmd.cell_y * COLS + cmd.cell_x] = (cmd.command == gaps_pkg::CMD_SET);
            end else if (cmd.command == gaps_pkg::CMD_FIND) begin
                plan_route(cmd.cell_x, cmd.cell_y, cmd.goal_x, cmd.goal_y);
            end
        endfunction

        function void check_word(gaps_pkg::t_out_word got);
            gaps_pkg::t_out_word want;
            words_checked++;
            if (pending_steps.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word st=%0d x=%0d y=%0d last=%0d",
                         $time, got.status, got.step_x, got.step_y, got.last);
                return;
            end
            want = pending_steps.pop_front();
            if (got.status !== want.status || got.step_x !== want.step_x ||
                got.step_y !== want.step_y || got.last !== want.last) begin
                mismatches++;
                $display("%0t: expected st=%0d x=%0d y=%0d last=%0d, got st=%0d x=%0d y=%0d last=%0d",
                         $time, want.status, want.step_x, want.step_y, want.last,
                         got.status, got.step_x, got.step_y, got.last);
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    gaps_pkg::t_in_word           i_data;
    logic                         o_valid;
    logic                         i_ready;
    gaps_pkg::t_out_word          o_data;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic                         i_cfg_index;
    logic [gaps_pkg::DIM_W-1:0]   i_cfg_data;

    path_scoreboard route_sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    grid_astar_path_search #(.MAX_COLUMNS(COLS), .MAX_ROWS(ROWS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_valid && i_ready) begin
            route_sb.check_word(o_data);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] cmd, int cx, int cy, int gx, int gy);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_data.command = cmd;
        i_data.cell_x  = cx[2:0];
        i_data.cell_y  = cy[2:0];
        i_data.goal_x  = gx[2:0];
        i_data.goal_y  = gy[2:0];
        i_valid        = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        route_sb.note_command(i_data);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_register(logic idx, int value);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = value[gaps_pkg::DIM_W-1:0];
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        route_sb.set_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (route_sb.pending_steps.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic random_phase(int count, int w, int h);
        int  r, ew, eh;
        ew = (w > COLS) ? COLS : ((w < 1) ? 1 : w);
        eh = (h > ROWS) ? ROWS : ((h < 1) ? 1 : h);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                send_word(gaps_pkg::CMD_SET, $urandom_range(ew - 1), $urandom_range(eh - 1),
                          $urandom, $urandom);
            end else if (r < 52) begin
                send_word(gaps_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 57) begin
                send_word(CMD_SPARE, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 90) begin
                send_word(gaps_pkg::CMD_FIND, $urandom_range(ew - 1), $urandom_range(eh - 1),
                          $urandom_range(ew - 1), $urandom_range(eh - 1));
            end else begin
                send_word(gaps_pkg::CMD_FIND, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        route_sb       = new();
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_data         = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = gaps_pkg::CFG_WIDTH;
        i_cfg_data     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Open grid searches, the trivial cases, a walled-in goal and an obstacle goal.
        send_word(gaps_pkg::CMD_FIND, 0, 0, 7, 7);
        send_word(gaps_pkg::CMD_FIND, 7, 7, 0, 0);
        send_word(gaps_pkg::CMD_FIND, 3, 4, 3, 4);
        send_word(gaps_pkg::CMD_FIND, 2, 2, 3, 2);
        send_word(gaps_pkg::CMD_FIND, 0, 7, 7, 0);
        send_word(gaps_pkg::CMD_SET, 6, 7, 0, 0);
        send_word(gaps_pkg::CMD_SET, 7, 6, 0, 0);
        send_word(gaps_pkg::CMD_FIND, 0, 0, 7, 7);
        send_word(gaps_pkg::CMD_SET, 7, 7, 0, 0);
        send_word(gaps_pkg::CMD_FIND, 7, 5, 7, 7);
        send_word(gaps_pkg::CMD_CLEAR, 6, 7, 0, 0);
        send_word(gaps_pkg::CMD_FIND, 0, 0, 7, 7);
        send_word(CMD_SPARE, 7, 7, 7, 7);
        send_word(gaps_pkg::CMD_CLEAR, 7, 6, 7, 7);
        send_word(gaps_pkg::CMD_CLEAR, 7, 7, 0, 0);
        for (int y = 0; y < 7; y++) send_word(gaps_pkg::CMD_SET, 4, y, 0, 0);
        send_word(gaps_pkg::CMD_FIND, 0, 0, 7, 0);
        random_phase(12, COLS, ROWS);
        wait_idle();

        write_register(gaps_pkg::CFG_WIDTH, 15);
        write_register(gaps_pkg::CFG_HEIGHT, 15);
        random_phase(18, 15, 15);
        wait_idle();

        send_idle_pct = 74;
        write_register(gaps_pkg::CFG_WIDTH, 5);
        write_register(gaps_pkg::CFG_HEIGHT, 3);
        random_phase(18, 5, 3);
        wait_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 74;
        write_register(gaps_pkg::CFG_WIDTH, 1);
        write_register(gaps_pkg::CFG_HEIGHT, 8);
        send_word(gaps_pkg::CMD_FIND, 0, 0, 0, 7);
        random_phase(12, 1, 8);
        wait_idle();

        send_idle_pct  = 16;
        recv_stall_pct = 16;
        write_register(gaps_pkg::CFG_WIDTH, 0);
        write_register(gaps_pkg::CFG_HEIGHT, 8);
        send_word(gaps_pkg::CMD_FIND, 0, 0, 1, 1);
        wait_idle();
        write_register(gaps_pkg::CFG_WIDTH, 8);
        write_register(gaps_pkg::CFG_HEIGHT, 0);
        send_word(gaps_pkg::CMD_FIND, 0, 0, 1, 1);
        wait_idle();
        write_register(gaps_pkg::CFG_HEIGHT, 7);
        random_phase(18, 8, 7);
        wait_idle();

        $display("Ran %0d searches and checked %0d output words over seven grid settings,",
                 route_sb.searches, route_sb.words_checked);
        $display("with and without sender gaps and receiver stalls.");
        if (route_sb.mismatches == 0 && route_sb.pending_steps.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
